FILE: hw/rtl/rqs_pkg.sv
`timescale 1ns / 1ps

package rqs_pkg;

  // Field widths of the beats
  localparam int unsigned TID_W  = 16;
  localparam int unsigned PID_W  = 16;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned OCC_W  = 6;
  localparam int unsigned MODE_W = 2;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Policy codes; the fourth code is unused
  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MLQ  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [TID_W-1:0]  thread_id;
    logic [PID_W-1:0]  process_id;
    logic [PRIO_W-1:0] priority_req;
  } rqs_in_t;

  typedef struct packed {
    logic              found;
    logic              overflow;
    logic [TID_W-1:0]  out_thread_id;
    logic [PID_W-1:0]  out_process_id;
    logic [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;
  } rqs_out_t;

  // One stored thread
  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } rqs_entry_t;

  localparam int unsigned ENTRY_W = $bits(rqs_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_FIFO_ENT,
    ST_PRIO_LVL,
    ST_DEQ,
    ST_NOP
  } rqs_state_e;

endpackage

FILE: hw/rtl/rqs_in_if.sv
`timescale 1ns / 1ps

interface rqs_in_if;
  import rqs_pkg::*;

  logic    valid;
  logic    ready;
  rqs_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rqs_out_if.sv
`timescale 1ns / 1ps

interface rqs_out_if;
  import rqs_pkg::*;

  logic     valid;
  logic     ready;
  rqs_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rqs_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, read data holds while re_i is low.
module rqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ready_queue_scheduler.sv
`timescale 1ns / 1ps
// Sequence: an enqueue or no-op beat passes through ST_ENQ or ST_NOP, a dequeue through
// ST_FIFO_ENT or ST_PRIO_LVL and then ST_DEQ (level table read and entry read in series);
// the result register loads as that last state ends, once no earlier beat occupies it.
// Flow: one item in flight; a new beat is accepted only after the last one's result has
// loaded, as set by the read-then-write sequence on the single-port-per-direction link memories.
// Reset: queue empty, policy FIFO; no clearing pass, a fill counter hands out fresh slots.

module ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH     = 32,
  parameter int unsigned PRIORITY_LEVELS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rqs_pkg::MODE_W-1:0] cfg_data_i,
  rqs_in_if.sink                     in_i,
  rqs_out_if.source                  out_o
);
  import rqs_pkg::*;

  // Storage layout
  //   data_ram  : per slot {tid, pid, prio}
  //   lnext_ram : per slot, next slot in the same level; for free slots, next free slot
  //   gprev_ram,
  //   gnext_ram : per slot, doubly linked global arrival order (needed to unlink a
  //               level head from the middle of the global order in priority modes)
  //   lvl_ram   : per level {head, tail}; level_nonempty bits live in flops
  // The global head is the oldest thread, and so always the head of its own level,
  // which lets FIFO mode reuse the level lists.
  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W  = $clog2(PRIORITY_LEVELS);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);

  rqs_state_e state_q, state_d;

  logic [MODE_W-1:0]          mode_q, mode_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           fill_q, fill_d;        // slots ever handed out
  logic [SLOT_W-1:0]          free_head_q, free_head_d;
  logic [SLOT_W-1:0]          ghead_q, ghead_d;
  logic [SLOT_W-1:0]          gtail_q, gtail_d;
  logic [PRIORITY_LEVELS-1:0] nonempty_q, nonempty_d;
  logic                       out_valid_q, out_valid_d;
  rqs_out_t                   out_q, out_d;
  rqs_in_t                    item_q, item_d;        // accepted beat, priority saturated
  logic [SLOT_W-1:0]          slot_q, slot_d;        // slot being dequeued
  logic [LVL_W-1:0]           lvl_q, lvl_d;          // its level

  logic in_accept;
  logic out_free;
  logic full;
  logic deq_ok;

  logic [PRIO_W-1:0]          in_prio_sat;
  logic [LVL_W-1:0]           in_lvl;
  logic [LVL_W-1:0]           item_lvl;
  logic [PRIORITY_LEVELS-1:0] lowest_bit;
  logic [LVL_W-1:0]           pick_lvl;

  logic              enq_pop;
  logic [SLOT_W-1:0] enq_slot;

  // Memory ports
  logic              ent_re;
  logic              pop_re;
  logic [SLOT_W-1:0] ent_raddr;

  logic              data_we;
  logic [SLOT_W-1:0] data_waddr;
  rqs_entry_t        data_wdata;
  logic [ENTRY_W-1:0] data_rdata;
  rqs_entry_t        data_rd;

  logic              lnext_we;
  logic [SLOT_W-1:0] lnext_waddr;
  logic [SLOT_W-1:0] lnext_wdata;
  logic              lnext_re;
  logic [SLOT_W-1:0] lnext_raddr;
  logic [SLOT_W-1:0] lnext_rd;

  logic              gprev_we;
  logic [SLOT_W-1:0] gprev_waddr;
  logic [SLOT_W-1:0] gprev_wdata;
  logic [SLOT_W-1:0] gprev_rd;

  logic              gnext_we;
  logic [SLOT_W-1:0] gnext_waddr;
  logic [SLOT_W-1:0] gnext_wdata;
  logic [SLOT_W-1:0] gnext_rd;

  logic                  lvl_we;
  logic [LVL_W-1:0]      lvl_waddr;
  logic [2*SLOT_W-1:0]   lvl_wdata;
  logic                  lvl_re;
  logic [LVL_W-1:0]      lvl_raddr;
  logic [2*SLOT_W-1:0]   lvl_rdata;
  logic [SLOT_W-1:0]     lvl_head;
  logic [SLOT_W-1:0]     lvl_tail;

  logic [OCC_W+CNT_W-1:0] occ_ext;

  // ---------------------------------------------------------------------------
  // Handshake and small decodes
  // ---------------------------------------------------------------------------
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_accept   = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;
  // Result register is free this cycle if empty or being drained
  assign out_free    = ~out_valid_q | out_o.ready;

  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  // Unused policy code: dequeue reports not found and leaves the queue alone
  assign deq_ok = (count_q != '0) &&
                  ((mode_q == MODE_FIFO) || (mode_q == MODE_PRIO) || (mode_q == MODE_MLQ));

  // Priorities past the last level clamp to it
  always_comb begin
    if (32'(in_i.payload.priority_req) > PRIORITY_LEVELS - 1) begin
      in_prio_sat = PRIO_W'(PRIORITY_LEVELS - 1);
    end else begin
      in_prio_sat = in_i.payload.priority_req;
    end
  end

  assign in_lvl   = LVL_W'(in_prio_sat);
  assign item_lvl = LVL_W'(item_q.priority_req);

  // Lowest non-empty level: isolate the lowest set bit, then encode it
  assign lowest_bit = nonempty_q & (~nonempty_q + 1'b1);

  always_comb begin
    pick_lvl = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (lowest_bit[i]) begin
        pick_lvl = pick_lvl | LVL_W'(i);
      end
    end
  end

  // Slot for an enqueue: recycle from the free list when it holds anything,
  // otherwise take the next never-used slot
  assign enq_pop  = (fill_q != count_q);
  assign enq_slot = enq_pop ? free_head_q : fill_q[SLOT_W-1:0];

  assign data_rd  = rqs_entry_t'(data_rdata);
  assign lvl_head = lvl_rdata[2*SLOT_W-1:SLOT_W];
  assign lvl_tail = lvl_rdata[SLOT_W-1:0];

  assign lnext_re    = ent_re | pop_re;
  assign lnext_raddr = pop_re ? free_head_q : ent_raddr;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_i.payload.cmd == CMD_ENQ) begin
            state_d = full ? ST_NOP : ST_ENQ;
          end else if (!deq_ok) begin
            state_d = ST_NOP;
          end else if (mode_q == MODE_FIFO) begin
            state_d = ST_FIFO_ENT;
          end else begin
            state_d = ST_PRIO_LVL;
          end
        end
      end
      ST_FIFO_ENT,
      ST_PRIO_LVL: begin
        state_d = ST_DEQ;
      end
      ST_ENQ,
      ST_DEQ,
      ST_NOP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory control: reads, then write-back in the commit state
  // ---------------------------------------------------------------------------
  always_comb begin
    ent_re      = 1'b0;
    pop_re      = 1'b0;
    ent_raddr   = '0;
    lvl_re      = 1'b0;
    lvl_raddr   = '0;
    data_we     = 1'b0;
    data_waddr  = '0;
    data_wdata  = '0;
    lnext_we    = 1'b0;
    lnext_waddr = '0;
    lnext_wdata = '0;
    gprev_we    = 1'b0;
    gprev_waddr = '0;
    gprev_wdata = '0;
    gnext_we    = 1'b0;
    gnext_waddr = '0;
    gnext_wdata = '0;
    lvl_we      = 1'b0;
    lvl_waddr   = '0;
    lvl_wdata   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_i.payload.cmd == CMD_ENQ) begin
            if (!full) begin
              // level {head, tail} and next free slot
              lvl_re    = 1'b1;
              lvl_raddr = in_lvl;
              pop_re    = 1'b1;
            end
          end else if (deq_ok) begin
            if (mode_q == MODE_FIFO) begin
              ent_re    = 1'b1;
              ent_raddr = ghead_q;
            end else begin
              lvl_re    = 1'b1;
              lvl_raddr = pick_lvl;
            end
          end
        end
      end
      ST_FIFO_ENT: begin
        // oldest entry known; fetch its level
        lvl_re    = 1'b1;
        lvl_raddr = LVL_W'(data_rd.prio);
      end
      ST_PRIO_LVL: begin
        // level head known; fetch the entry and its links
        ent_re    = 1'b1;
        ent_raddr = lvl_head;
      end
      ST_ENQ: begin
        if (out_free) begin
          data_we    = 1'b1;
          data_waddr = enq_slot;
          data_wdata = '{tid:  item_q.thread_id,
                         pid:  item_q.process_id,
                         prio: item_q.priority_req};
          // append to the global order
          if (count_q != '0) begin
            gprev_we    = 1'b1;
            gprev_waddr = enq_slot;
            gprev_wdata = gtail_q;
            gnext_we    = 1'b1;
            gnext_waddr = gtail_q;
            gnext_wdata = enq_slot;
          end
          // append to the level list
          lvl_we    = 1'b1;
          lvl_waddr = item_lvl;
          if (nonempty_q[item_lvl]) begin
            lnext_we    = 1'b1;
            lnext_waddr = lvl_tail;
            lnext_wdata = enq_slot;
            lvl_wdata   = {lvl_head, enq_slot};
          end else begin
            lvl_wdata   = {enq_slot, enq_slot};
          end
        end
      end
      ST_DEQ: begin
        if (out_free) begin
          // pop the level head; a last entry just clears the nonempty bit
          if (lvl_tail != slot_q) begin
            lvl_we    = 1'b1;
            lvl_waddr = lvl_q;
            lvl_wdata = {lnext_rd, lvl_tail};
          end
          // unlink from the global order
          if (slot_q != ghead_q) begin
            gnext_we    = 1'b1;
            gnext_waddr = gprev_rd;
            gnext_wdata = gnext_rd;
          end
          if (slot_q != gtail_q) begin
            gprev_we    = 1'b1;
            gprev_waddr = gnext_rd;
            gprev_wdata = gprev_rd;
          end
          // push onto the free list
          lnext_we    = 1'b1;
          lnext_waddr = slot_q;
          lnext_wdata = free_head_q;
        end
      end
      ST_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Register next values
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d      = cfg_we_i ? cfg_data_i : mode_q;
    count_d     = count_q;
    fill_d      = fill_q;
    free_head_d = free_head_q;
    ghead_d     = ghead_q;
    gtail_d     = gtail_q;
    nonempty_d  = nonempty_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_d       = out_q;
    item_d      = item_q;
    slot_d      = slot_q;
    lvl_d       = lvl_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          item_d              = in_i.payload;
          item_d.priority_req = in_prio_sat;
          if (in_i.payload.cmd == CMD_DEQ) begin
            slot_d = ghead_q;
            lvl_d  = pick_lvl;
          end
        end
      end
      ST_FIFO_ENT: begin
        lvl_d = LVL_W'(data_rd.prio);
      end
      ST_PRIO_LVL: begin
        slot_d = lvl_head;
      end
      ST_ENQ: begin
        if (out_free) begin
          count_d = count_q + 1'b1;
          if (enq_pop) begin
            free_head_d = lnext_rd;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          if (count_q == '0) begin
            ghead_d = enq_slot;
          end
          gtail_d              = enq_slot;
          nonempty_d[item_lvl] = 1'b1;
          out_valid_d          = 1'b1;
          out_d                = '0;
        end
      end
      ST_DEQ: begin
        if (out_free) begin
          count_d     = count_q - 1'b1;
          free_head_d = slot_q;
          if (slot_q == ghead_q) begin
            ghead_d = gnext_rd;
          end
          if (slot_q == gtail_q) begin
            gtail_d = gprev_rd;
          end
          if (lvl_tail == slot_q) begin
            nonempty_d[lvl_q] = 1'b0;
          end
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.found          = 1'b1;
          out_d.out_thread_id  = data_rd.tid;
          out_d.out_process_id = data_rd.pid;
          out_d.out_priority   = data_rd.prio;
        end
      end
      ST_NOP: begin
        // full store on enqueue, or empty store / unused policy on dequeue
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d          = '0;
          out_d.overflow = (item_q.cmd == CMD_ENQ);
        end
      end
      default: begin
      end
    endcase

    // occupancy after this item, low bits
    occ_ext = {{OCC_W{1'b0}}, count_d};
    if ((state_q == ST_ENQ || state_q == ST_DEQ || state_q == ST_NOP) && out_free) begin
      out_d.occupancy = occ_ext[OCC_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FIFO;
      count_q     <= '0;
      fill_q      <= '0;
      free_head_q <= '0;
      ghead_q     <= '0;
      gtail_q     <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      free_head_q <= free_head_d;
      ghead_q     <= ghead_d;
      gtail_q     <= gtail_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    item_q <= item_d;
    slot_q <= slot_d;
    lvl_q  <= lvl_d;
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  rqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (data_rdata)
  );

  rqs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_lnext_ram (
    .clk_i   (clk_i),
    .we_i    (lnext_we),
    .waddr_i (lnext_waddr),
    .wdata_i (lnext_wdata),
    .re_i    (lnext_re),
    .raddr_i (lnext_raddr),
    .rdata_o (lnext_rd)
  );

  rqs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_gprev_ram (
    .clk_i   (clk_i),
    .we_i    (gprev_we),
    .waddr_i (gprev_waddr),
    .wdata_i (gprev_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (gprev_rd)
  );

  rqs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_gnext_ram (
    .clk_i   (clk_i),
    .we_i    (gnext_we),
    .waddr_i (gnext_waddr),
    .wdata_i (gnext_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (gnext_rd)
  );

  rqs_ram #(
    .WIDTH (2 * SLOT_W),
    .DEPTH (PRIORITY_LEVELS)
  ) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (lvl_re),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

endmodule

FILE: tb/sv/rqs_order_checker.sv
`timescale 1ns / 1ps

// Watches the input and result channels, keeps its own copy of the ready queue
// and compares every result beat against the oldest predicted one.
module rqs_order_checker #(
  parameter int unsigned QUEUE_DEPTH     = 32,
  parameter int unsigned PRIORITY_LEVELS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rqs_pkg::MODE_W-1:0] cfg_data_i,
  rqs_in_if                          in_i,
  rqs_out_if                         out_i,
  output int unsigned                mismatches_o,
  output int unsigned                owed_o,
  output int unsigned                results_o,
  output int unsigned                handed_out_o,
  output int unsigned                no_thread_o,
  output int unsigned                dropped_o
);
  import rqs_pkg::*;

  // Stored threads in arrival order
  rqs_entry_t        ready_list[$];
  rqs_out_t          owed_results[$];
  logic [MODE_W-1:0] policy     = MODE_FIFO;
  int unsigned       mismatches = 0;
  int unsigned       results    = 0;
  int unsigned       handed_out = 0;
  int unsigned       no_thread  = 0;
  int unsigned       dropped    = 0;

  function automatic rqs_out_t schedule_op(rqs_in_t b);
    rqs_out_t   r;
    rqs_entry_t e;
    int         pick;
    r    = '0;
    pick = 0;
    if (b.cmd == CMD_ENQ) begin
      if (ready_list.size() >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
        dropped++;
      end else begin
        e.tid  = b.thread_id;
        e.pid  = b.process_id;
        e.prio = b.priority_req;
        if (e.prio > PRIORITY_LEVELS - 1) e.prio = PRIO_W'(PRIORITY_LEVELS - 1);
        ready_list.push_back(e);
      end
    end else if (ready_list.size() > 0 &&
                 (policy == MODE_FIFO || policy == MODE_PRIO || policy == MODE_MLQ)) begin
      // both level policies: oldest thread of the lowest level number
      if (policy != MODE_FIFO) begin
        for (int i = 1; i < ready_list.size(); i++) begin
          if (ready_list[i].prio < ready_list[pick].prio) pick = i;
        end
      end
      r.found          = 1'b1;
      r.out_thread_id  = ready_list[pick].tid;
      r.out_process_id = ready_list[pick].pid;
      r.out_priority   = ready_list[pick].prio;
      ready_list.delete(pick);
      handed_out++;
    end else begin
      no_thread++;
    end
    r.occupancy = OCC_W'(ready_list.size());
    return r;
  endfunction

  task automatic check_result(rqs_out_t act);
    rqs_out_t want;
    string    bad;
    results++;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result beat with nothing pending: tid=%h pid=%h", $realtime,
                 act.out_thread_id, act.out_process_id);
      return;
    end
    want = owed_results.pop_front();
    bad  = "";
    if (act.found !== want.found)                   bad = {bad, " found"};
    if (act.overflow !== want.overflow)             bad = {bad, " overflow"};
    if (act.out_thread_id !== want.out_thread_id)   bad = {bad, " out_thread_id"};
    if (act.out_process_id !== want.out_process_id) bad = {bad, " out_process_id"};
    if (act.out_priority !== want.out_priority)     bad = {bad, " out_priority"};
    if (act.occupancy !== want.occupancy)           bad = {bad, " occupancy"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch in%s", $realtime, bad);
        $display("  expected found=%b ovf=%b tid=%h pid=%h prio=%0d occ=%0d",
                 want.found, want.overflow, want.out_thread_id, want.out_process_id,
                 want.out_priority, want.occupancy);
        $display("  actual   found=%b ovf=%b tid=%h pid=%h prio=%0d occ=%0d",
                 act.found, act.overflow, act.out_thread_id, act.out_process_id,
                 act.out_priority, act.occupancy);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_list.delete();
      owed_results.delete();
      policy = MODE_FIFO;
    end else begin
      if (out_i.valid && out_i.ready) check_result(out_i.payload);
      if (in_i.valid && in_i.ready) owed_results.push_back(schedule_op(in_i.payload));
      if (cfg_we_i) policy = cfg_data_i;
    end
    // published with NBAs so the stimulus side reads a stable value
    mismatches_o <= mismatches;
    owed_o       <= owed_results.size();
    results_o    <= results;
    handed_out_o <= handed_out;
    no_thread_o  <= no_thread;
    dropped_o    <= dropped;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the ready queue scheduler. Prediction and checking
// live in rqs_order_checker; this module only drives beats and decides.
module testbench;
  import rqs_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 32;
  localparam int unsigned PRIORITY_LEVELS = 16;
  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 62;   // ~500 random beats overall
  localparam int unsigned FILL_ITEMS      = 40;   // enqueue-heavy head of each phase
  localparam int unsigned HOLD_CYCLES     = 300;  // long output hold-off
  localparam int unsigned DRAIN_CYCLES    = 10;   // settle time after the last result
  localparam int unsigned TIMEOUT_CYCLES  = 500_000;

  // Policy code with no meaning: dequeues report nothing and remove nothing
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Policy per random phase, phase 0 in the low bits
  localparam logic [PHASES*MODE_W-1:0] POLICY_PLAN = {
    MODE_MLQ, MODE_FIFO, MODE_PRIO, MODE_MLQ, MODE_UNUSED, MODE_MLQ, MODE_PRIO, MODE_FIFO
  };

  logic              clk;
  logic              rst_ni;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_data;

  rqs_in_if  in_ch ();
  rqs_out_if out_ch ();

  // Idle / stall percentages, set per phase by the stimulus process
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // Long hold-off: requested by the stimulus, counted by the receiver
  logic        hold_req   = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  int unsigned mismatches;
  int unsigned owed;
  int unsigned results;
  int unsigned handed_out;
  int unsigned no_thread;
  int unsigned dropped;

  ready_queue_scheduler #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  rqs_order_checker #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .mismatches_o(mismatches),
    .owed_o      (owed),
    .results_o   (results),
    .handed_out_o(handed_out),
    .no_thread_o (no_thread),
    .dropped_o   (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: result beats stopped arriving");
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and has to stall its input while the sender keeps offering beats.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until
  // accepted. valid is left high at the accept edge so the next call can
  // keep it up without a low pulse.
  task automatic send_beat(rqs_in_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic push_thread(logic [TID_W-1:0] tid, logic [PID_W-1:0] pid,
                             logic [PRIO_W-1:0] prio);
    send_beat('{cmd: CMD_ENQ, thread_id: tid, process_id: pid, priority_req: prio});
  endtask

  task automatic pop_thread();
    send_beat('{cmd: CMD_DEQ, thread_id: '0, process_id: '0, priority_req: '0});
  endtask

  // Policy register is only touched with nothing in flight: wait until every
  // predicted result has been taken, then write it on a quiet input.
  task automatic set_policy(logic [MODE_W-1:0] mode);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random beat. Priorities lean toward a few low levels to force ties;
  // ids hit their extremes now and then. Dequeue beats carry junk payload.
  function automatic rqs_in_t random_beat(int unsigned enq_pct);
    rqs_in_t b;
    b.cmd        = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    b.thread_id  = TID_W'($urandom);
    b.process_id = PID_W'($urandom);
    case ($urandom_range(3))
      0:       b.priority_req = PRIO_W'($urandom_range(2));
      1:       b.priority_req = $urandom_range(1) ? '1 : '0;
      default: b.priority_req = PRIO_W'($urandom_range(15));
    endcase
    if ($urandom_range(15) == 0) b.thread_id = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(15) == 0) b.process_id = $urandom_range(1) ? '1 : '0;
    return b;
  endfunction

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = MODE_FIFO;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;

    // ---- directed ----
    // FIFO: empty dequeue, id extremes, arrival order regardless of level
    set_policy(MODE_FIFO);
    pop_thread();
    push_thread(16'h0000, 16'hFFFF, 4'd15);
    push_thread(16'hFFFF, 16'h0000, 4'd0);
    push_thread(16'h1234, 16'hABCD, 4'd7);
    pop_thread();
    pop_thread();
    pop_thread();
    pop_thread();

    // Lowest level first, ties broken by age
    set_policy(MODE_PRIO);
    push_thread(16'h0011, 16'h0101, 4'd9);
    push_thread(16'h0022, 16'h0202, 4'd3);
    push_thread(16'h0033, 16'h0303, 4'd3);
    push_thread(16'h0044, 16'h0404, 4'd15);
    pop_thread();
    pop_thread();
    push_thread(16'h0055, 16'h0505, 4'd0);
    pop_thread();

    // Unused code: dequeue gives nothing and keeps the queue, enqueue still works
    set_policy(MODE_UNUSED);
    pop_thread();
    push_thread(16'h0066, 16'h0606, 4'd9);

    // Multilevel: drain the leftovers (level 9 twice in age order, then 15)
    set_policy(MODE_MLQ);
    pop_thread();
    pop_thread();
    pop_thread();
    pop_thread();

    // ---- random phases ----
    // Each phase fills hard, then drains; the unused-code phase only grows the
    // queue, so the full-store drop is hit. Idle mix rotates every phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_policy(POLICY_PLAN[ph*MODE_W +: MODE_W]);
      case (ph % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 81;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 81;
        end
        default: begin
          src_idle_pct  = 34;
          snk_stall_pct = 34;
        end
      endcase
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_beat(random_beat(n < FILL_ITEMS ? 88 : 30));
    end

    // ---- wind down ----
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats: %0d threads handed out, %0d empty-handed dequeues,",
             results, handed_out, no_thread);
    $display("%0d enqueues dropped on a full queue; all four policy codes, four stall mixes.",
             dropped);
    if (mismatches == 0 && owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: ready_queue_scheduler.f
hw/rtl/rqs_pkg.sv
hw/rtl/rqs_in_if.sv
hw/rtl/rqs_out_if.sv
hw/rtl/rqs_ram.sv
hw/rtl/ready_queue_scheduler.sv
tb/sv/rqs_order_checker.sv
tb/sv/testbench.sv
